// ===== design/cdq_pkg.sv =====
// Package for the circular deque unit: opcode, status and cell command codes.
// No dependencies; every other design file imports it.
`default_nettype none

package cdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5,
        OP_CLEAR      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD      = 3'd0,
        CMD_SHIFT_IN  = 3'd1,
        CMD_SHIFT_OUT = 3'd2,
        CMD_LOAD_REAR = 3'd3,
        CMD_DROP_REAR = 3'd4,
        CMD_CLEAR     = 3'd5
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/cdq_cell.sv =====
// One storage cell of the deque chain: a word, its valid bit and the rear tap.
// Depends on cdq_pkg for the cell command codes.
`default_nettype none

module cdq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cdq_pkg::cell_cmd_t           cmd,
    input  wire logic signed [DATA_WIDTH-1:0] word,
    input  wire logic signed [DATA_WIDTH-1:0] prev_data,
    input  wire logic                         prev_valid,
    input  wire logic signed [DATA_WIDTH-1:0] next_data,
    input  wire logic                         next_valid,
    output logic signed [DATA_WIDTH-1:0]      data,
    output logic                              valid,
    output logic        [DATA_WIDTH-1:0]      rear_tap
);
    import cdq_pkg::*;

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;
    logic                         valid_reg;
    logic                         valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_SHIFT_IN:
            begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            CMD_SHIFT_OUT:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            CMD_LOAD_REAR:
            begin
                if (!valid_reg && prev_valid)
                begin
                    data_next  = word;
                    valid_next = 1'b1;
                end
            end
            CMD_DROP_REAR:
            begin
                if (valid_reg && !next_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign rear_tap = (valid_reg && !next_valid) ? data_reg : '0;

endmodule

`default_nettype wire

// ===== design/circular_deque_unit.sv =====
// Top level of the circular deque unit: a packed chain of cells with the front
// at cell 0, command decode, rear word select and the result register.
// Depends on cdq_pkg and cdq_cell.
//
//   channel   signals                      handshake
//   command   start, opcode, value         start && !busy
//   result    done, data, status, count    done, one cycle, no stall
//
// One word is taken every cycle; busy stays low.
// The result appears with done in the cycle after the word is taken.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears the valid bits and the fill count at once; no clearing pass.
`default_nettype none

module circular_deque_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   opcode,
    input  wire logic signed [DATA_WIDTH-1:0] value,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      data,
    output cdq_pkg::status_t                  status,
    output logic [CW-1:0]                     count
);
    import cdq_pkg::*;

    logic signed [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic        [DEPTH-1:0]      cell_valid;
    logic        [DATA_WIDTH-1:0] cell_tap   [DEPTH];
    logic        [DEPTH-1:0]      tap_col    [DATA_WIDTH];
    logic        [DATA_WIDTH-1:0] rear_word;

    logic [CW-1:0]                fill_count_reg;
    logic [CW-1:0]                fill_count_next;
    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;
    status_t                      status_reg;
    status_t                      status_next;

    cell_cmd_t cmd;
    logic      accept;
    logic      full;
    logic      empty;
    op_t       op;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = op_t'(opcode);
    assign full   = (fill_count_reg == CW'(DEPTH));
    assign empty  = (fill_count_reg == '0);

    genvar gi, gb;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] prev_d;
            logic                         prev_v;
            logic signed [DATA_WIDTH-1:0] next_d;
            logic                         next_v;

            if (gi == 0)
            begin : g_first
                assign prev_d = value;
                assign prev_v = 1'b1;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_data[gi-1];
                assign prev_v = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_d = '0;
                assign next_v = 1'b0;
            end
            else
            begin : g_mid_next
                assign next_d = cell_data[gi+1];
                assign next_v = cell_valid[gi+1];
            end

            cdq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .word       (value),
                .prev_data  (prev_d),
                .prev_valid (prev_v),
                .next_data  (next_d),
                .next_valid (next_v),
                .data       (cell_data[gi]),
                .valid      (cell_valid[gi]),
                .rear_tap   (cell_tap[gi])
            );

            for (gb = 0; gb < DATA_WIDTH; gb++)
            begin : g_col
                assign tap_col[gb][gi] = cell_tap[gi][gb];
            end
        end

        for (gb = 0; gb < DATA_WIDTH; gb++)
        begin : g_rear
            assign rear_word[gb] = |tap_col[gb];
        end
    endgenerate

    always_comb
    begin
        cmd             = CMD_HOLD;
        fill_count_next = fill_count_reg;
        data_next       = '0;
        status_next     = ST_OK;
        if (accept)
        begin
            case (op)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd             = (op == OP_PUSH_FRONT) ? CMD_SHIFT_IN : CMD_LOAD_REAR;
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_REAR, OP_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        data_next   = '1;
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                        begin
                            data_next = cell_data[0];
                        end
                        else
                        begin
                            data_next = $signed(rear_word);
                        end
                        if (op == OP_POP_FRONT)
                        begin
                            cmd             = CMD_SHIFT_OUT;
                            fill_count_next = fill_count_reg - 1'b1;
                        end
                        else if (op == OP_POP_REAR)
                        begin
                            cmd             = CMD_DROP_REAR;
                            fill_count_next = fill_count_reg - 1'b1;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    cmd             = CMD_CLEAR;
                    fill_count_next = '0;
                end
                default:
                begin
                    cmd = CMD_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            done_reg       <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign done   = done_reg;
    assign data   = data_reg;
    assign status = status_reg;
    assign count  = fill_count_reg;

endmodule

`default_nettype wire

// ===== design/cdq_checker.sv =====
// Port-level checks for circular_deque_unit and the bind that attaches them.
// Depends on cdq_pkg for the status codes.
`default_nettype none

module cdq_checker #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic signed [DATA_WIDTH-1:0] data,
    input wire cdq_pkg::status_t             status,
    input wire logic [CW-1:0]                count
);
    import cdq_pkg::*;

    a_done_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after a taken word");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a taken word");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OVERFLOW) |-> (count == CW'(DEPTH)))
        else $error("overflow while not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_UNDERFLOW) |-> (count == '0 && data == '1))
        else $error("underflow result malformed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count <= CW'(DEPTH)))
        else $error("count beyond depth");

endmodule

bind circular_deque_unit cdq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_cdq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .data   (data),
    .status (status),
    .count  (count)
);

`default_nettype wire
